>>> rtl/core/assert_macros.svh
// assertion macros for the set rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define BIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every clock edge, reset included
`define BIS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/bis_pkg.sv
// shared types, codes and widths for the bounded integer set
package bis_pkg;

  // field widths
  localparam int DEPTH_DEF = 64;
  localparam int ACT_W     = 2;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;
  localparam int POS_W     = 6;
  localparam int CNT_W     = 7;
  localparam int CAP_W     = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // request kinds
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUP    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd3;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_req;
    logic rd_cur;
    logic rd_next;
    logic inc_idx;
    logic set_hit;
    logic wr_shift;
    logic finish;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_end;
    logic match;
    logic shift_end;
    logic is_remove;
    logic out_busy;
  } dp_stat_t;

endpackage

>>> rtl/core/bis_ctrl.sv
// controller state machine for the bounded integer set
module bis_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  bis_pkg::dp_stat_t stat,
  output bis_pkg::dp_cmd_t  cmd
);
  import bis_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_READ;
        end
      end
      S_READ: begin
        if (stat.scan_end) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd_cur = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.match) begin
          cmd.set_hit = 1'b1;
          state_next  = stat.is_remove ? S_SHIFT_RD : S_FINISH;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = S_READ;
        end
      end
      S_SHIFT_RD: begin
        if (stat.shift_end) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd_next = 1'b1;
          state_next  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.inc_idx  = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // one item at a time
  assign in_stall = (state != S_IDLE);

endmodule

>>> rtl/core/bis_dp.sv
// datapath for the bounded integer set: entry memory, count, index and result register
`include "assert_macros.svh"
module bis_dp #(
  parameter int DEPTH = bis_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bis_pkg::CAP_W-1:0]   cfg_data,
  input  logic [bis_pkg::ACT_W-1:0]   action,
  input  logic signed [bis_pkg::VAL_W-1:0] value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bis_pkg::STAT_W-1:0]  status,
  output logic                        found,
  output logic [bis_pkg::POS_W-1:0]   position,
  output logic [bis_pkg::CNT_W-1:0]   count,
  input  bis_pkg::dp_cmd_t            cmd,
  output bis_pkg::dp_stat_t           stat
);
  import bis_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;
  localparam int PW = (AW > POS_W) ? AW : POS_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic             we;

  logic [CAP_W-1:0] capacity;
  logic [CW-1:0]    held;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    idx_inc;
  logic [ACT_W-1:0] action_r;
  logic [VAL_W-1:0] value_r;
  logic             hit;
  logic [AW-1:0]    pos;

  logic             is_add;
  logic             is_remove;
  logic             full;
  logic             add_ok;
  logic             rem_ok;
  logic [STAT_W-1:0] status_next;
  logic [CW-1:0]    held_next;
  logic [PW-1:0]    pos_ext;
  logic [MW-1:0]    held_ext;

  assign cfg_ready = 1'b1;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // request decode and full check against min(capacity, depth)
  assign is_add    = (action_r == ACT_ADD);
  assign is_remove = (action_r == ACT_REMOVE);
  assign full      = (MW'(held) >= MW'(capacity)) || (held >= DEPTH_C);
  assign add_ok    = is_add && !full && !hit;
  assign rem_ok    = is_remove && hit;
  assign idx_inc   = idx + 1'b1;

  // entry memory ports
  assign raddr = cmd.rd_next ? idx_inc[AW-1:0] : idx[AW-1:0];
  assign waddr = cmd.wr_shift ? idx[AW-1:0] : held[AW-1:0];
  assign wdata = cmd.wr_shift ? rdata : value_r;
  assign we    = cmd.wr_shift || (cmd.finish && add_ok);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_cur || cmd.rd_next) begin
      rdata <= mem[raddr];
    end
  end

  // request registers, scan index and search result
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      action_r <= action;
      value_r  <= value;
      idx      <= '0;
      hit      <= 1'b0;
      pos      <= '0;
    end else begin
      if (cmd.set_hit) begin
        hit <= 1'b1;
        pos <= idx[AW-1:0];
      end
      if (cmd.inc_idx) begin
        idx <= idx_inc;
      end
    end
  end

  // status toward the controller
  assign stat.scan_end  = (idx >= held);
  assign stat.match     = (rdata == value_r);
  assign stat.shift_end = (idx_inc >= held);
  assign stat.is_remove = is_remove;
  assign stat.out_busy  = out_valid && out_stall;

  // result status and count update
  always_comb begin
    held_next = held;
    if (is_add) begin
      if (full) begin
        status_next = ST_FULL;
      end else if (hit) begin
        status_next = ST_DUP;
      end else begin
        status_next = ST_DONE;
        held_next   = held + 1'b1;
      end
    end else if (is_remove) begin
      if (hit) begin
        status_next = ST_DONE;
        held_next   = held - 1'b1;
      end else begin
        status_next = ST_ABSENT;
      end
    end else begin
      status_next = hit ? ST_DONE : ST_ABSENT;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (cmd.finish) begin
      held <= held_next;
    end
  end

  assign pos_ext  = PW'(pos);
  assign held_ext = MW'(held_next);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status   <= status_next;
      found    <= hit;
      position <= pos_ext[POS_W-1:0];
      count    <= held_ext[CNT_W-1:0];
    end
  end

  // checks
  `BIS_ASSERT_ALWAYS(a_held_bound, (rst || held <= DEPTH_C), "entry count above depth")
  `BIS_ASSERT(a_add_grows, (cmd.finish && add_ok) |=> (held == $past(held) + 1'b1), "add did not grow count")
  `BIS_ASSERT(a_rem_shrinks, (cmd.finish && rem_ok) |=> (held == $past(held) - 1'b1), "remove did not shrink count")
  `BIS_ASSERT(a_dup_found, (out_valid && status == ST_DUP) |-> found, "duplicate status without match")

endmodule

>>> rtl/core/bounded_integer_set.sv
// top level of the bounded integer set
// Holds up to min(capacity, DEPTH) signed 32-bit values in insertion order, and serves
// one add, remove or query item at a time. An item searches the entries one by one,
// reading each through the registered read port of the entry memory and comparing it; a
// remove that hits then moves each later entry down one place, through the separate
// write port. The entries searched and moved by a remove that hits add up to the count
// held. The next item is taken as soon as the previous one has left the result
// register's input side; a result waits in the output register while the next item is
// accepted. The entry memory needs no clearing pass after reset. The user must write
// capacity through the cfg port only while no item is in flight; the block does not
// enforce this. Action code three acts as a query.
module bounded_integer_set #(
  parameter int DEPTH = bis_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bis_pkg::CAP_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bis_pkg::ACT_W-1:0]   action,
  input  logic signed [bis_pkg::VAL_W-1:0] value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bis_pkg::STAT_W-1:0]  status,
  output logic                        found,
  output logic [bis_pkg::POS_W-1:0]   position,
  output logic [bis_pkg::CNT_W-1:0]   count
);
  import bis_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  bis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // entry storage and result logic
  bis_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .action    (action),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .found     (found),
    .position  (position),
    .count     (count),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
